[hdl/mtm_pkg.sv]
// Package for the multi timer manager: request and result codes, widths.
// Used by the interfaces, the timer cell and the top level.
package mtm_pkg;
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_STOP  = 2'd1;
   localparam logic [1:0] REQ_RESET = 2'd2;
   localparam logic [1:0] REQ_TICK  = 2'd3;

   localparam logic [2:0] KIND_START  = 3'd0;
   localparam logic [2:0] KIND_STOP   = 3'd1;
   localparam logic [2:0] KIND_RESET  = 3'd2;
   localparam logic [2:0] KIND_EXPIRY = 3'd3;
   localparam logic [2:0] KIND_TICK   = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_ID  = 2'd1;
   localparam logic [1:0] ST_NO_FREE = 2'd2;
   localparam logic [1:0] ST_NEG_DUR = 2'd3;

   localparam logic [1:0] CSR_TICK_MS     = 2'd0;
   localparam logic [1:0] CSR_EARLY_MS    = 2'd1;
   localparam logic [1:0] CSR_REPEAT_CODE = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [5:0]         timer_id;
      logic signed [31:0] duration_ms;
      logic signed [31:0] user_arg1;
      logic signed [31:0] user_arg2;
      logic signed [31:0] user_arg3;
   } req_type_type;

   typedef struct packed {
      logic [2:0]         result_kind;
      logic [1:0]         status;
      logic [5:0]         out_id;
      logic signed [31:0] out_arg1;
      logic signed [31:0] out_arg2;
      logic signed [31:0] out_arg3;
      logic               last;
   } rsp_type;

   // One timer entry as it circulates along the chain.
   typedef struct packed {
      logic        active;
      logic [5:0]  id;
      logic [31:0] start_time;
      logic [31:0] duration;
      logic [31:0] arg1;
      logic [31:0] arg2;
      logic [31:0] arg3;
   } entry_type;
endpackage

[hdl/mtm_req_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on mtm_pkg.
interface mtm_req_if;
   logic                 valid;
   logic                 ready;
   mtm_pkg::req_type_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mtm_rsp_if;
   logic            valid;
   logic            ready;
   mtm_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hdl/mtm_cell.sv]
// One timer entry register of the rotating chain; passes its entry to the next cell.
// Depends on mtm_pkg.
module mtm_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  logic [5:0]          reset_id,
   input  mtm_pkg::entry_type  entry_in,
   output mtm_pkg::entry_type  entry_out
);
   mtm_pkg::entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.active <= 1'b0;
         entry_ff.id     <= reset_id;
      end else if (shift) begin
         entry_ff.active <= entry_in.active;
         entry_ff.id     <= entry_in.id;
      end
      if (shift) begin
         entry_ff.start_time <= entry_in.start_time;
         entry_ff.duration   <= entry_in.duration;
         entry_ff.arg1       <= entry_in.arg1;
         entry_ff.arg2       <= entry_in.arg2;
         entry_ff.arg3       <= entry_in.arg3;
      end
   end

   assign entry_out = entry_ff;
endmodule

[hdl/mtm_id_pool.sv]
// FIFO of free timer IDs, reset to 1..depth in order.
// Depends on nothing but its parameter.
module mtm_id_pool #(
   parameter int NUM_TIMERS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       pop,
   input  logic       push,
   input  logic [5:0] push_id,
   output logic [5:0] head_id,
   output logic       empty
);
   localparam int PW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);

   logic [5:0]    ids_ff [NUM_TIMERS];
   logic [PW-1:0] pop_ff, push_ff;
   logic [CW-1:0] count_ff;

   function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
      return (p == PW'(NUM_TIMERS - 1)) ? '0 : p + PW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_ff   <= '0;
         push_ff  <= '0;
         count_ff <= CW'(NUM_TIMERS);
         for (int i = 0; i < NUM_TIMERS; i++) ids_ff[i] <= 6'(i + 1);
      end else begin
         if (pop) pop_ff <= inc(pop_ff);
         if (push) begin
            ids_ff[push_ff] <= push_id;
            push_ff         <= inc(push_ff);
         end
         if (pop && !push) count_ff <= count_ff - CW'(1);
         else if (push && !pop && count_ff != CW'(NUM_TIMERS))
            count_ff <= count_ff + CW'(1);
      end
   end

   assign head_id = ids_ff[pop_ff];
   assign empty   = (count_ff == '0);
endmodule

[hdl/multi_timer_manager_unit.sv]
// Multi timer manager: timers in a rotating chain of cells, free IDs in a FIFO.
// A tick, or a start, stop or reset that passes its checks, turns the chain once: it shifts
// until every entry has passed the head, then a closing state gives the final result, and the
// next item is taken when the result output is free. A tick holds its shift while a waiting
// expiry cannot be given out; rejected requests answer from the idle state without a pass.
// Synchronous active-high reset clears all timers, refills the ID pool and restores the registers.
module multi_timer_manager_unit #(
   parameter int NUM_TIMERS = 32
) (
   input  logic        clock,
   input  logic        reset,
   mtm_req_if.sink     req,
   mtm_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [9:0]  tick_ms_ff, early_ms_ff;
   logic [31:0] repeat_code_ff, now_ms_ff;
   logic [1:0]  state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   mtm_pkg::req_type_type cur_ff;
   logic [5:0]  start_id_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   mtm_pkg::rsp_type rsp_ff, rsp_in, rsp_acc;
   logic        rsp_load;
   logic        accept, quick, stop_miss;
   logic [1:0]  quick_st;

   mtm_pkg::entry_type chain [NUM_TIMERS+1];
   mtm_pkg::entry_type head, head_new;
   logic shift;
   logic pool_pop, pool_push, pool_empty;
   logic [5:0] pool_head;

   assign head = chain[NUM_TIMERS];
   assign chain[0] = head_new;

   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
      mtm_cell u_cell (
         .clock(clock), .reset(reset), .shift(shift),
         .reset_id(6'(NUM_TIMERS - g)),
         .entry_in(chain[g]), .entry_out(chain[g+1]));
   end

   mtm_id_pool #(.NUM_TIMERS(NUM_TIMERS)) u_pool (
      .clock(clock), .reset(reset), .pop(pool_pop), .push(pool_push),
      .push_id(head.id), .head_id(pool_head), .empty(pool_empty));

   logic [32:0] elapsed;
   logic        expired, id_ok, dur_neg, hit, out_free;
   always_comb begin
      elapsed  = {1'b0, now_ms_ff - head.start_time} + 33'(early_ms_ff);
      expired  = head.active && (elapsed > {1'b0, head.duration});
      id_ok    = cur_ff.timer_id >= 6'd1 && cur_ff.timer_id <= 6'(NUM_TIMERS);
      dur_neg  = cur_ff.duration_ms[31];
      hit      = head.id == ((cur_ff.req_type == mtm_pkg::REQ_START) ?
                             start_id_ff : cur_ff.timer_id);
      out_free = !rsp_valid_ff || rsp.ready;
   end

   always_comb begin
      quick    = 1'b0;
      quick_st = mtm_pkg::ST_OK;
      rsp_acc  = '0;
      rsp_acc.last = 1'b1;
      case (req.payload.req_type)
         mtm_pkg::REQ_START: begin
            if (req.payload.duration_ms[31]) begin
               quick = 1'b1; quick_st = mtm_pkg::ST_NEG_DUR;
            end else if (pool_empty) begin
               quick = 1'b1; quick_st = mtm_pkg::ST_NO_FREE;
            end
            rsp_acc.result_kind = mtm_pkg::KIND_START;
            rsp_acc.out_id      = quick ? 6'd0 : pool_head;
         end
         mtm_pkg::REQ_STOP: begin
            if (req.payload.timer_id < 6'd1 || req.payload.timer_id > 6'(NUM_TIMERS)) begin
               quick = 1'b1; quick_st = mtm_pkg::ST_BAD_ID;
            end
            rsp_acc.result_kind = mtm_pkg::KIND_STOP;
            rsp_acc.out_id      = req.payload.timer_id;
         end
         mtm_pkg::REQ_RESET: begin
            if (req.payload.timer_id < 6'd1 || req.payload.timer_id > 6'(NUM_TIMERS)) begin
               quick = 1'b1; quick_st = mtm_pkg::ST_BAD_ID;
            end else if (req.payload.duration_ms[31]) begin
               quick = 1'b1; quick_st = mtm_pkg::ST_NEG_DUR;
            end
            rsp_acc.result_kind = mtm_pkg::KIND_RESET;
            rsp_acc.out_id      = req.payload.timer_id;
         end
         default: ;
      endcase
      rsp_acc.status = quick_st;
   end

   assign req.ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req.valid && req.ready;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      shift     = 1'b0;
      head_new  = head;
      pool_push = 1'b0;
      rsp_load  = 1'b0;
      rsp_in    = '0;
      rsp_in.last = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               if (req.payload.req_type == mtm_pkg::REQ_TICK || !quick) state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cur_ff.req_type == mtm_pkg::REQ_TICK) begin
               if (!expired || out_free) begin
                  shift  = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
                  if (expired) begin
                     rsp_load = 1'b1;
                     rsp_in.result_kind = mtm_pkg::KIND_EXPIRY;
                     rsp_in.out_id = head.id;
                     rsp_in.out_arg1 = head.arg1;
                     rsp_in.out_arg2 = head.arg2;
                     rsp_in.out_arg3 = head.arg3;
                     rsp_in.last = 1'b0;
                     if (head.arg3 == repeat_code_ff) begin
                        if (!head.arg2[31]) begin
                           head_new.start_time = now_ms_ff;
                           head_new.duration   = head.arg2;
                        end
                     end else begin
                        head_new.active = 1'b0;
                        pool_push = 1'b1;
                     end
                  end
               end
            end else begin
               shift  = 1'b1;
               cnt_in = cnt_ff + CW'(1);
               if (hit) begin
                  case (cur_ff.req_type)
                     mtm_pkg::REQ_START: begin
                        head_new.active = 1'b1;
                        head_new.start_time = now_ms_ff;
                        head_new.duration = cur_ff.duration_ms;
                        head_new.arg1 = cur_ff.user_arg1;
                        head_new.arg2 = cur_ff.user_arg2;
                        head_new.arg3 = cur_ff.user_arg3;
                     end
                     mtm_pkg::REQ_STOP: begin
                        if (head.active) begin
                           head_new.active = 1'b0;
                           pool_push = 1'b1;
                        end
                     end
                     mtm_pkg::REQ_RESET: begin
                        if (head.active && id_ok && !dur_neg) begin
                           head_new.start_time = now_ms_ff;
                           head_new.duration = cur_ff.duration_ms;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            if (cnt_in == CW'(NUM_TIMERS)) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               if (cur_ff.req_type == mtm_pkg::REQ_TICK) rsp_in.result_kind = mtm_pkg::KIND_TICK;
               else rsp_in = rsp_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // A stop of an entry that turns out to be inactive is rejected when the entry passes.
   assign stop_miss = (state_ff == S_SCAN) && (cur_ff.req_type == mtm_pkg::REQ_STOP) &&
                      hit && !head.active;
   assign rsp_valid_in = rsp_load || (accept && quick) || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ms_ff     <= 10'd100;
         early_ms_ff    <= 10'd10;
         repeat_code_ff <= 32'd1;
         now_ms_ff      <= '0;
         state_ff       <= S_IDLE;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mtm_pkg::CSR_TICK_MS:     tick_ms_ff     <= csr_wdata[9:0];
               mtm_pkg::CSR_EARLY_MS:    early_ms_ff    <= csr_wdata[9:0];
               mtm_pkg::CSR_REPEAT_CODE: repeat_code_ff <= csr_wdata;
               default: ;
            endcase
         end
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept && req.payload.req_type == mtm_pkg::REQ_TICK)
            now_ms_ff <= now_ms_ff + 32'(tick_ms_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff      <= req.payload;
         start_id_ff <= pool_head;
         rsp_ff      <= rsp_acc;
      end else if (rsp_load) begin
         rsp_ff <= rsp_in;
      end else if (stop_miss) begin
         rsp_ff.status <= mtm_pkg::ST_BAD_ID;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   assign pool_pop = accept && req.payload.req_type == mtm_pkg::REQ_START && !quick;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready)
      else $error("request taken during a pass");
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("result lost");
   assert property (@(posedge clock) disable iff (reset)
      !(pool_pop && pool_empty))
      else $error("pop from empty ID pool");
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.payload)))
      else $error("waiting result changed");
endmodule
